>>> hdl/dlbm_pkg.sv
`default_nettype none
package dlbm_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_VARIANT     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_LATCH_INIT  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_WINDOW_LOW  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_WINDOW_HIGH = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_BUS_CONFL   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_LARGE_PRG   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_HDR_MIRR    = 3'd6;

  localparam logic [15:0] WINDOW_LOW_RST  = 16'h8000;
  localparam logic [15:0] WINDOW_HIGH_RST = 16'hFFFF;

  localparam logic [7:0] LAST_BANK = 8'hFF;

  // Mirroring codes
  localparam logic [1:0] MIRR_HORIZ = 2'd0;
  localparam logic [1:0] MIRR_VERT  = 2'd1;

  // Board variants
  localparam logic [4:0] VAR_UNROM   = 5'd0;
  localparam logic [4:0] VAR_CNROM   = 5'd1;
  localparam logic [4:0] VAR_AXROM   = 5'd2;
  localparam logic [4:0] VAR_B8      = 5'd3;
  localparam logic [4:0] VAR_B11     = 5'd4;
  localparam logic [4:0] VAR_CPROM   = 5'd5;
  localparam logic [4:0] VAR_B36     = 5'd6;
  localparam logic [4:0] VAR_B38     = 5'd7;
  localparam logic [4:0] VAR_GXROM   = 5'd8;
  localparam logic [4:0] VAR_B70     = 5'd9;
  localparam logic [4:0] VAR_B78     = 5'd10;
  localparam logic [4:0] VAR_B86     = 5'd11;
  localparam logic [4:0] VAR_B87     = 5'd12;
  localparam logic [4:0] VAR_B89     = 5'd13;
  localparam logic [4:0] VAR_B93     = 5'd14;
  localparam logic [4:0] VAR_B94     = 5'd15;
  localparam logic [4:0] VAR_B97     = 5'd16;
  localparam logic [4:0] VAR_B101    = 5'd17;
  localparam logic [4:0] VAR_B107    = 5'd18;
  localparam logic [4:0] VAR_B113    = 5'd19;
  localparam logic [4:0] VAR_B152    = 5'd20;
  localparam logic [4:0] VAR_B180    = 5'd21;
  localparam logic [4:0] VAR_B184    = 5'd22;
  localparam logic [4:0] VAR_B203    = 5'd23;
  localparam logic [4:0] VAR_B240    = 5'd24;
  localparam logic [4:0] VAR_B241    = 5'd25;
  localparam logic [4:0] VAR_A65AS   = 5'd26;
  localparam logic [4:0] VAR_M11160  = 5'd27;

  typedef struct packed {
    logic [4:0]  variant;
    logic [7:0]  latch_init;
    logic [15:0] window_low;
    logic [15:0] window_high;
    logic        bus_conflicts;
    logic        large_prg;
    logic [1:0]  header_mirroring;
  } cfg_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] address;
    logic [7:0]  data;
    logic [7:0]  rom_byte;
  } item_t;

  typedef struct packed {
    logic       prg_32k_mode;
    logic [7:0] prg_bank_first;
    logic [7:0] prg_bank_second;
    logic       chr_4k_mode;
    logic [7:0] chr_bank_first;
    logic [7:0] chr_bank_second;
    logic       work_ram_mapped;
  } bank_map_t;

  typedef struct packed {
    logic [7:0] latch_value;
    bank_map_t  bank_map;
    logic [1:0] mirroring;
    logic       write_taken;
  } result_t;

endpackage
`default_nettype wire

>>> hdl/dlbm_cfg_regs.sv
`default_nettype none
module dlbm_cfg_regs
  import dlbm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_VARIANT:     cfg_d.variant          = cfg_wdata_i[4:0];
        REG_LATCH_INIT:  cfg_d.latch_init       = cfg_wdata_i[7:0];
        REG_WINDOW_LOW:  cfg_d.window_low       = cfg_wdata_i;
        REG_WINDOW_HIGH: cfg_d.window_high      = cfg_wdata_i;
        REG_BUS_CONFL:   cfg_d.bus_conflicts    = cfg_wdata_i[0];
        REG_LARGE_PRG:   cfg_d.large_prg        = cfg_wdata_i[0];
        REG_HDR_MIRR:    cfg_d.header_mirroring = cfg_wdata_i[1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.variant          <= VAR_UNROM;
      cfg_q.latch_init       <= '0;
      cfg_q.window_low       <= WINDOW_LOW_RST;
      cfg_q.window_high      <= WINDOW_HIGH_RST;
      cfg_q.bus_conflicts    <= 1'b0;
      cfg_q.large_prg        <= 1'b0;
      cfg_q.header_mirroring <= MIRR_HORIZ;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

>>> hdl/dlbm_in_reg.sv
`default_nettype none
module dlbm_in_reg
  import dlbm_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t item_i,
  input  logic  take_i,     // downstream consumes the held item this cycle
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;
  logic  load;

  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = load || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule
`default_nettype wire

>>> hdl/dlbm_decode.sv
`default_nettype none
module dlbm_decode
  import dlbm_pkg::*;
(
  input  logic [4:0] variant_i,
  input  logic       large_prg_i,
  input  logic [7:0] latch_i,
  input  logic       sticky_i,
  input  logic [1:0] mirr_i,
  output bank_map_t  map_o,
  output logic       sticky_o,
  output logic [1:0] mirr_o
);

  logic [7:0] L;
  logic [7:0] chr;
  logic       sticky_new;

  assign L          = latch_i;
  assign sticky_new = sticky_i | L[3];

  always_comb begin
    map_o = '0;
    map_o.prg_32k_mode = 1'b1;
    chr      = '0;
    sticky_o = sticky_i;
    mirr_o   = mirr_i;
    unique case (variant_i)
      VAR_UNROM: begin
        map_o.prg_32k_mode    = 1'b0;
        map_o.prg_bank_second = LAST_BANK;
        if (!large_prg_i) begin
          map_o.prg_bank_first = {5'd0, L[2:0]};
          sticky_o = sticky_new;
          if (sticky_new) mirr_o = {1'b0, ~L[3]};
        end else begin
          map_o.prg_bank_first = {4'd0, L[3:0]};
        end
      end
      VAR_CNROM: begin
        chr = L;
        map_o.work_ram_mapped = 1'b1;
      end
      VAR_AXROM: begin
        map_o.prg_bank_first = {4'd0, L[3:0]};
        mirr_o = {1'b1, L[4]};
      end
      VAR_B8: begin
        map_o.prg_32k_mode    = 1'b0;
        map_o.prg_bank_first  = {3'd0, L[7:3]};
        map_o.prg_bank_second = 8'd1;
        chr = {6'd0, L[1:0]};
      end
      VAR_B11: begin
        map_o.prg_bank_first = {4'd0, L[3:0]};
        chr = {4'd0, L[7:4]};
      end
      VAR_CPROM: begin
        map_o.chr_4k_mode     = 1'b1;
        map_o.chr_bank_second = {6'd0, L[1:0]};
      end
      VAR_B36, VAR_GXROM: begin
        map_o.prg_bank_first = {4'd0, L[7:4]};
        chr = {4'd0, L[3:0]};
      end
      VAR_B38: begin
        map_o.prg_bank_first = {6'd0, L[1:0]};
        chr = {2'd0, L[7:2]};
      end
      VAR_B70: begin
        map_o.prg_32k_mode    = 1'b0;
        map_o.prg_bank_first  = {4'd0, L[7:4]};
        map_o.prg_bank_second = LAST_BANK;
        chr = {4'd0, L[3:0]};
      end
      VAR_B78: begin
        map_o.prg_32k_mode    = 1'b0;
        map_o.prg_bank_first  = {5'd0, L[2:0]};
        map_o.prg_bank_second = LAST_BANK;
        chr    = {4'd0, L[7:4]};
        mirr_o = {1'b1, L[3]};
      end
      VAR_B86: begin
        map_o.prg_bank_first = {6'd0, L[5:4]};
        chr = {5'd0, L[6], L[1:0]};
      end
      VAR_B87: begin
        chr = {6'd0, L[0], L[1]};   // two CHR select bits are swapped on this board
      end
      VAR_B89: begin
        map_o.prg_32k_mode    = 1'b0;
        map_o.prg_bank_first  = {5'd0, L[6:4]};
        map_o.prg_bank_second = LAST_BANK;
        chr    = {4'd0, L[7], L[2:0]};
        mirr_o = {1'b1, L[3]};
      end
      VAR_B93: begin
        map_o.prg_32k_mode    = 1'b0;
        map_o.prg_bank_first  = {4'd0, L[7:4]};
        map_o.prg_bank_second = LAST_BANK;
      end
      VAR_B94: begin
        map_o.prg_32k_mode    = 1'b0;
        map_o.prg_bank_first  = {2'd0, L[7:2]};
        map_o.prg_bank_second = LAST_BANK;
      end
      VAR_B97: begin
        map_o.prg_32k_mode    = 1'b0;
        map_o.prg_bank_first  = LAST_BANK;
        map_o.prg_bank_second = {4'd0, L[3:0]};
        chr = {6'd0, L[0], L[1]};
        if (L[7:6] == 2'd1) begin
          mirr_o = MIRR_HORIZ;
        end else if (L[7:6] == 2'd2) begin
          mirr_o = MIRR_VERT;
        end
      end
      VAR_B101: begin
        chr = L;
      end
      VAR_B107: begin
        map_o.prg_bank_first = {6'd0, L[2:1]};
        chr = {5'd0, L[2:0]};
      end
      VAR_B113: begin
        map_o.prg_bank_first = {5'd0, L[5:3]};
        chr = {4'd0, L[6], L[2:0]};
      end
      VAR_B152: begin
        map_o.prg_32k_mode    = 1'b0;
        map_o.prg_bank_first  = {5'd0, L[6:4]};
        map_o.prg_bank_second = LAST_BANK;
        chr    = {4'd0, L[3:0]};
        mirr_o = {1'b1, L[7]};
      end
      VAR_B180: begin
        map_o.prg_32k_mode    = 1'b0;
        map_o.prg_bank_second = L;
      end
      VAR_B184: begin
        map_o.chr_4k_mode     = 1'b1;
        map_o.chr_bank_first  = L;
        map_o.chr_bank_second = {4'd0, L[7:4]};
      end
      VAR_B203: begin
        map_o.prg_32k_mode    = 1'b0;
        map_o.prg_bank_first  = {6'd0, L[3:2]};
        map_o.prg_bank_second = {6'd0, L[3:2]};
        chr = {6'd0, L[1:0]};
      end
      VAR_B240: begin
        map_o.prg_bank_first  = {4'd0, L[7:4]};
        chr = {4'd0, L[3:0]};
        map_o.work_ram_mapped = 1'b1;
      end
      VAR_B241: begin
        map_o.prg_bank_first  = L;
        map_o.work_ram_mapped = 1'b1;
      end
      VAR_A65AS: begin
        if (L[6]) begin
          map_o.prg_bank_first = {4'd0, L[4:1]};
        end else begin
          map_o.prg_32k_mode    = 1'b0;
          map_o.prg_bank_first  = {3'd0, L[5:4], L[2:0]};
          map_o.prg_bank_second = {3'd0, L[5:4], 3'b111};
        end
        if (L[7]) begin
          mirr_o = {1'b1, L[5]};
        end else begin
          mirr_o = {1'b0, ~L[3]};
        end
      end
      VAR_M11160: begin
        map_o.prg_bank_first = {5'd0, L[6:4]};
        chr    = {3'd0, L[6:4], L[1:0]};
        mirr_o = {1'b0, L[7]};
      end
      default: begin
        // unused variant codes: 32 KiB bank 0, 8 KiB pattern bank 0
        chr = '0;
      end
    endcase
    if (!map_o.chr_4k_mode) begin
      map_o.chr_bank_first  = chr;
      map_o.chr_bank_second = '0;
    end
  end

endmodule
`default_nettype wire

>>> hdl/discrete_latch_bank_mapper.sv
// Path: an input transfer is held in the input register, then decoded into the
// result register once that register is free or is being emptied.
// Throughput: one item per cycle while the output is not stalled; the latch update
// and decode of one item fit in the single stage between the two registers.
// Reset (rst_ni low, asynchronous): valid flags cleared, latch, sticky
// mirroring enable and mirroring cleared, config registers to their defaults.
`default_nettype none
module discrete_latch_bank_mapper
  import dlbm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                mode_i,
  input  logic [15:0]         address_i,
  input  logic [7:0]          data_i,
  input  logic [7:0]          rom_byte_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          latch_value_o,
  output logic                prg_32k_mode_o,
  output logic [7:0]          prg_bank_first_o,
  output logic [7:0]          prg_bank_second_o,
  output logic                chr_4k_mode_o,
  output logic [7:0]          chr_bank_first_o,
  output logic [7:0]          chr_bank_second_o,
  output logic [1:0]          mirroring_o,
  output logic                work_ram_mapped_o,
  output logic                write_taken_o
);

  cfg_t      cfg;
  item_t     item_in, item;
  logic      item_valid;
  logic      take, fire;
  logic      out_valid_q, out_valid_d;
  result_t   res_q, res_d;
  logic [7:0] latch_q, latch_d;
  logic       sticky_q, sticky_d;
  logic [1:0] mirr_q, mirr_d, mirr_pre;
  logic       in_window;
  bank_map_t  bank_map;

  dlbm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign item_in.mode     = mode_i;
  assign item_in.address  = address_i;
  assign item_in.data     = data_i;
  assign item_in.rom_byte = rom_byte_i;

  // the result register is free, or is being emptied this cycle
  assign take = !out_valid_q || out_ready_i;
  assign fire = item_valid && take;

  dlbm_in_reg u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (item_in),
    .take_i     (take),
    .valid_o    (item_valid),
    .item_o     (item)
  );

  assign in_window = (item.address >= cfg.window_low) && (item.address <= cfg.window_high);

  always_comb begin
    latch_d  = latch_q;
    mirr_pre = mirr_q;
    if (item.mode) begin
      latch_d  = cfg.latch_init;
      mirr_pre = cfg.header_mirroring;
    end else if (in_window) begin
      latch_d = cfg.bus_conflicts ? (item.data & item.rom_byte) : item.data;
    end
  end

  dlbm_decode u_dec (
    .variant_i   (cfg.variant),
    .large_prg_i (cfg.large_prg),
    .latch_i     (latch_d),
    .sticky_i    (sticky_q),
    .mirr_i      (mirr_pre),
    .map_o       (bank_map),
    .sticky_o    (sticky_d),
    .mirr_o      (mirr_d)
  );

  assign res_d.latch_value = latch_d;
  assign res_d.bank_map    = bank_map;
  assign res_d.mirroring   = mirr_d;
  assign res_d.write_taken = item.mode || in_window;

  assign out_valid_d = fire || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      latch_q     <= '0;
      sticky_q    <= 1'b0;
      mirr_q      <= MIRR_HORIZ;
    end else begin
      out_valid_q <= out_valid_d;
      if (fire) begin
        latch_q  <= latch_d;
        sticky_q <= sticky_d;
        mirr_q   <= mirr_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign latch_value_o     = res_q.latch_value;
  assign prg_32k_mode_o    = res_q.bank_map.prg_32k_mode;
  assign prg_bank_first_o  = res_q.bank_map.prg_bank_first;
  assign prg_bank_second_o = res_q.bank_map.prg_bank_second;
  assign chr_4k_mode_o     = res_q.bank_map.chr_4k_mode;
  assign chr_bank_first_o  = res_q.bank_map.chr_bank_first;
  assign chr_bank_second_o = res_q.bank_map.chr_bank_second;
  assign mirroring_o       = res_q.mirroring;
  assign work_ram_mapped_o = res_q.bank_map.work_ram_mapped;
  assign write_taken_o     = res_q.write_taken;

endmodule
`default_nettype wire

>>> hdl/dlbm_checker.sv
`default_nettype none
module dlbm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] latch_value_o,
  input logic       prg_32k_mode_o,
  input logic [7:0] prg_bank_second_o,
  input logic       chr_4k_mode_o,
  input logic [7:0] chr_bank_second_o
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(latch_value_o))
    else $error("latch value changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && prg_32k_mode_o |-> prg_bank_second_o == 8'd0)
    else $error("second PRG bank set in 32 KiB mode");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !chr_4k_mode_o |-> chr_bank_second_o == 8'd0)
    else $error("second CHR bank set in 8 KiB mode");

endmodule

bind discrete_latch_bank_mapper dlbm_checker u_dlbm_checker (.*);
`default_nettype wire

>>> tb/sv/discrete_latch_bank_mapper_test.sv
`default_nettype none
module discrete_latch_bank_mapper_test;
  import dlbm_pkg::*;

  localparam logic       MODE_WRITE      = 1'b0;
  localparam logic       MODE_POWER      = 1'b1;
  localparam logic [1:0] MIRR_SCREEN_B   = 2'd3;
  localparam logic [4:0] VAR_SPARE_FIRST = 5'd28;
  localparam logic [4:0] VAR_SPARE_LAST  = 5'd31;
  localparam int unsigned LATENCY        = 2;
  localparam int unsigned WATCHDOG_LIMIT = 400;
  localparam int unsigned ITEM_TARGET    = 1050;

  typedef struct packed {
    logic                is_cfg;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] wdata;
    item_t               acc;
    logic                typed;
    result_t             want;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                mode_i;
  logic [15:0]         address_i;
  logic [7:0]          data_i;
  logic [7:0]          rom_byte_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [7:0]          latch_value_o;
  logic                prg_32k_mode_o;
  logic [7:0]          prg_bank_first_o;
  logic [7:0]          prg_bank_second_o;
  logic                chr_4k_mode_o;
  logic [7:0]          chr_bank_first_o;
  logic [7:0]          chr_bank_second_o;
  logic [1:0]          mirroring_o;
  logic                work_ram_mapped_o;
  logic                write_taken_o;

  // predictor state
  cfg_t       mapper_cfg;
  logic [7:0] latch_q;
  logic       sticky_q;
  logic [1:0] mirr_q;

  result_t     pending_maps[$];
  stim_row_t   plan[$];
  int unsigned errors;
  int unsigned quiet_cycles;
  logic        steady;

  discrete_latch_bank_mapper uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .mode_i           (mode_i),
    .address_i        (address_i),
    .data_i           (data_i),
    .rom_byte_i       (rom_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .latch_value_o    (latch_value_o),
    .prg_32k_mode_o   (prg_32k_mode_o),
    .prg_bank_first_o (prg_bank_first_o),
    .prg_bank_second_o(prg_bank_second_o),
    .chr_4k_mode_o    (chr_4k_mode_o),
    .chr_bank_first_o (chr_bank_first_o),
    .chr_bank_second_o(chr_bank_second_o),
    .mirroring_o      (mirroring_o),
    .work_ram_mapped_o(work_ram_mapped_o),
    .write_taken_o    (write_taken_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Latch update plus board decode for one transfer.
  function automatic result_t map_access(input item_t acc);
    result_t    r;
    logic [7:0] l;
    logic       p32;
    logic       c4;
    logic       wram;
    logic [7:0] pa;
    logic [7:0] pb;
    logic [7:0] ca;
    logic [7:0] cb;
    r = '0;
    if (acc.mode == MODE_POWER) begin
      latch_q = mapper_cfg.latch_init;
      mirr_q = mapper_cfg.header_mirroring;
      r.write_taken = 1'b1;
    end else if (acc.address >= mapper_cfg.window_low &&
                 acc.address <= mapper_cfg.window_high) begin
      latch_q = mapper_cfg.bus_conflicts ? (acc.data & acc.rom_byte) : acc.data;
      r.write_taken = 1'b1;
    end
    l = latch_q;
    p32 = 1'b1;
    c4 = 1'b0;
    wram = 1'b0;
    pa = '0;
    pb = '0;
    ca = '0;
    cb = '0;
    case (mapper_cfg.variant)
      VAR_UNROM: begin
        p32 = 1'b0;
        pb = LAST_BANK;
        if (mapper_cfg.large_prg) begin
          pa = {4'h0, l[3:0]};
        end else begin
          pa = {5'h0, l[2:0]};
          // once bit 3 has been seen, mirroring follows its inverse
          if (l[3]) sticky_q = 1'b1;
          if (sticky_q) mirr_q = {1'b0, ~l[3]};
        end
      end
      VAR_CNROM: begin
        ca = l;
        wram = 1'b1;
      end
      VAR_AXROM: begin
        pa = {4'h0, l[3:0]};
        mirr_q = {1'b1, l[4]};
      end
      VAR_B8: begin
        p32 = 1'b0;
        pa = {3'h0, l[7:3]};
        pb = 8'd1;
        ca = {6'h0, l[1:0]};
      end
      VAR_B11: begin
        pa = {4'h0, l[3:0]};
        ca = {4'h0, l[7:4]};
      end
      VAR_CPROM: begin
        c4 = 1'b1;
        cb = {6'h0, l[1:0]};
      end
      VAR_B36, VAR_GXROM: begin
        pa = {4'h0, l[7:4]};
        ca = {4'h0, l[3:0]};
      end
      VAR_B38: begin
        pa = {6'h0, l[1:0]};
        ca = {2'h0, l[7:2]};
      end
      VAR_B70: begin
        p32 = 1'b0;
        pa = {4'h0, l[7:4]};
        pb = LAST_BANK;
        ca = {4'h0, l[3:0]};
      end
      VAR_B78: begin
        p32 = 1'b0;
        pa = {5'h0, l[2:0]};
        pb = LAST_BANK;
        ca = {4'h0, l[7:4]};
        mirr_q = {1'b1, l[3]};
      end
      VAR_B86: begin
        pa = {6'h0, l[5:4]};
        ca = {5'h0, l[6], l[1:0]};
      end
      VAR_B87: begin
        ca = {6'h0, l[0], l[1]};
      end
      VAR_B89: begin
        p32 = 1'b0;
        pa = {5'h0, l[6:4]};
        pb = LAST_BANK;
        ca = {4'h0, l[7], l[2:0]};
        mirr_q = {1'b1, l[3]};
      end
      VAR_B93: begin
        p32 = 1'b0;
        pa = {4'h0, l[7:4]};
        pb = LAST_BANK;
      end
      VAR_B94: begin
        p32 = 1'b0;
        pa = {2'h0, l[7:2]};
        pb = LAST_BANK;
      end
      VAR_B97: begin
        p32 = 1'b0;
        pa = LAST_BANK;
        pb = {4'h0, l[3:0]};
        if (l[7:6] == 2'b01) mirr_q = MIRR_HORIZ;
        else if (l[7:6] == 2'b10) mirr_q = MIRR_VERT;
        ca = {6'h0, l[0], l[1]};
      end
      VAR_B101: begin
        ca = l;
      end
      VAR_B107: begin
        pa = {6'h0, l[2:1]};
        ca = {5'h0, l[2:0]};
      end
      VAR_B113: begin
        pa = {5'h0, l[5:3]};
        ca = {4'h0, l[6], l[2:0]};
      end
      VAR_B152: begin
        p32 = 1'b0;
        pa = {5'h0, l[6:4]};
        pb = LAST_BANK;
        ca = {4'h0, l[3:0]};
        mirr_q = {1'b1, l[7]};
      end
      VAR_B180: begin
        p32 = 1'b0;
        pb = l;
      end
      VAR_B184: begin
        c4 = 1'b1;
        ca = l;
        cb = {4'h0, l[7:4]};
      end
      VAR_B203: begin
        p32 = 1'b0;
        pa = {6'h0, l[3:2]};
        pb = pa;
        ca = {6'h0, l[1:0]};
      end
      VAR_B240: begin
        pa = {4'h0, l[7:4]};
        ca = {4'h0, l[3:0]};
        wram = 1'b1;
      end
      VAR_B241: begin
        pa = l;
        wram = 1'b1;
      end
      VAR_A65AS: begin
        if (l[6]) begin
          pa = {4'h0, l[4:1]};
        end else begin
          p32 = 1'b0;
          pa = {3'h0, l[5:4], l[2:0]};
          pb = {3'h0, l[5:4], 3'h7};
        end
        if (l[7]) mirr_q = {1'b1, l[5]};
        else mirr_q = {1'b0, ~l[3]};
      end
      VAR_M11160: begin
        pa = {5'h0, l[6:4]};
        ca = {3'h0, l[6:4], l[1:0]};
        mirr_q = {1'b0, l[7]};
      end
      default: begin
        // spare codes: fixed 32K bank 0, 8K pattern bank 0
      end
    endcase
    if (p32) pb = '0;
    if (!c4) cb = '0;
    r.latch_value = l;
    r.bank_map.prg_32k_mode = p32;
    r.bank_map.prg_bank_first = pa;
    r.bank_map.prg_bank_second = pb;
    r.bank_map.chr_4k_mode = c4;
    r.bank_map.chr_bank_first = ca;
    r.bank_map.chr_bank_second = cb;
    r.bank_map.work_ram_mapped = wram;
    r.mirroring = mirr_q;
    return r;
  endfunction

  function automatic result_t typed_map(input logic [7:0] lv, input logic p32,
                                        input logic [7:0] pa, input logic [7:0] pb,
                                        input logic c4, input logic [7:0] ca,
                                        input logic [7:0] cb, input logic wram,
                                        input logic [1:0] mi, input logic tk);
    return {lv, p32, pa, pb, c4, ca, cb, wram, mi, tk};
  endfunction

  function automatic stim_row_t reg_row(input logic [CfgIdxW-1:0] idx,
                                        input logic [CfgDataW-1:0] val);
    stim_row_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.idx = idx;
    s.wdata = val;
    return s;
  endfunction

  function automatic stim_row_t access_row(input logic m, input logic [15:0] a,
                                           input logic [7:0] d, input logic [7:0] rb,
                                           input logic typed, input result_t want);
    stim_row_t s;
    s = '0;
    s.acc.mode = m;
    s.acc.address = a;
    s.acc.data = d;
    s.acc.rom_byte = rb;
    s.typed = typed;
    s.want = want;
    return s;
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_VARIANT:     mapper_cfg.variant = val[4:0];
      REG_LATCH_INIT:  mapper_cfg.latch_init = val[7:0];
      REG_WINDOW_LOW:  mapper_cfg.window_low = val;
      REG_WINDOW_HIGH: mapper_cfg.window_high = val;
      REG_BUS_CONFL:   mapper_cfg.bus_conflicts = val[0];
      REG_LARGE_PRG:   mapper_cfg.large_prg = val[0];
      REG_HDR_MIRR:    mapper_cfg.header_mirroring = val[1:0];
      default: begin
      end
    endcase
    @(posedge clk_i);
  endtask

  // Drop valid and let every outstanding result come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_maps.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_access(input item_t acc, input logic typed, input result_t want);
    int unsigned gap;
    result_t     predicted;
    gap = steady ? 0 : $urandom_range(0, 9);
    cfg_we_i <= 1'b0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= acc.mode;
    address_i <= acc.address;
    data_i <= acc.data;
    rom_byte_i <= acc.rom_byte;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = map_access(acc);
    pending_maps.push_back(typed ? want : predicted);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : result_monitor
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_maps.size() == 0) begin
        $display("%0t: result with none expected, expected none got latch %h",
                 $time, latch_value_o);
        errors++;
      end else begin
        want = pending_maps.pop_front();
        check_field("latch_value", want.latch_value, latch_value_o);
        check_field("prg_32k_mode", 8'(want.bank_map.prg_32k_mode), 8'(prg_32k_mode_o));
        check_field("prg_bank_first", want.bank_map.prg_bank_first, prg_bank_first_o);
        check_field("prg_bank_second", want.bank_map.prg_bank_second, prg_bank_second_o);
        check_field("chr_4k_mode", 8'(want.bank_map.chr_4k_mode), 8'(chr_4k_mode_o));
        check_field("chr_bank_first", want.bank_map.chr_bank_first, chr_bank_first_o);
        check_field("chr_bank_second", want.bank_map.chr_bank_second, chr_bank_second_o);
        check_field("mirroring", 8'(want.mirroring), 8'(mirroring_o));
        check_field("work_ram_mapped", 8'(want.bank_map.work_ram_mapped),
                    8'(work_ram_mapped_o));
        check_field("write_taken", 8'(want.write_taken), 8'(write_taken_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin : result_sink
    int unsigned stall;
    out_ready_i = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  initial begin : stimulus
    int unsigned sent;
    int unsigned phase;
    int unsigned n;
    int unsigned lo;
    int unsigned hi;
    item_t       acc;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    mode_i = 1'b0;
    address_i = '0;
    data_i = '0;
    rom_byte_i = '0;
    steady = 1'b0;
    mapper_cfg = '0;
    mapper_cfg.window_low = WINDOW_LOW_RST;
    mapper_cfg.window_high = WINDOW_HIGH_RST;
    latch_q = '0;
    sticky_q = 1'b0;
    mirr_q = MIRR_HORIZ;

    // defaults after reset: UNROM, window 8000..FFFF, sticky mirroring clear
    plan.push_back(access_row(MODE_WRITE, 16'h8000, 8'h05, 8'h00, 1'b1,
      typed_map(8'h05, 1'b0, 8'h05, LAST_BANK, 1'b0, 8'h00, 8'h00, 1'b0, MIRR_HORIZ, 1'b1)));
    plan.push_back(access_row(MODE_WRITE, 16'h7FFF, 8'hFF, 8'hFF, 1'b1,
      typed_map(8'h05, 1'b0, 8'h05, LAST_BANK, 1'b0, 8'h00, 8'h00, 1'b0, MIRR_HORIZ, 1'b0)));
    plan.push_back(access_row(MODE_WRITE, 16'hFFFF, 8'h00, 8'hFF, 1'b1,
      typed_map(8'h00, 1'b0, 8'h00, LAST_BANK, 1'b0, 8'h00, 8'h00, 1'b0, MIRR_HORIZ, 1'b1)));
    // bit 3 arms sticky mirroring
    plan.push_back(access_row(MODE_WRITE, 16'hFFFF, 8'hFF, 8'h00, 1'b1,
      typed_map(8'hFF, 1'b0, 8'h07, LAST_BANK, 1'b0, 8'h00, 8'h00, 1'b0, MIRR_HORIZ, 1'b1)));
    plan.push_back(access_row(MODE_WRITE, 16'h8000, 8'h00, 8'h00, 1'b1,
      typed_map(8'h00, 1'b0, 8'h00, LAST_BANK, 1'b0, 8'h00, 8'h00, 1'b0, MIRR_VERT, 1'b1)));
    // power-up keeps the sticky enable, so decode overrides header mirroring
    plan.push_back(access_row(MODE_POWER, 16'h0000, 8'h00, 8'h00, 1'b1,
      typed_map(8'h00, 1'b0, 8'h00, LAST_BANK, 1'b0, 8'h00, 8'h00, 1'b0, MIRR_VERT, 1'b1)));
    plan.push_back(reg_row(REG_LARGE_PRG, 16'd1));
    plan.push_back(access_row(MODE_WRITE, 16'hC000, 8'hFF, 8'h00, 1'b0, '0));
    plan.push_back(reg_row(REG_VARIANT, 16'(VAR_CNROM)));
    plan.push_back(reg_row(REG_BUS_CONFL, 16'd1));
    plan.push_back(reg_row(REG_LARGE_PRG, 16'd0));
    plan.push_back(access_row(MODE_WRITE, 16'h9000, 8'hF0, 8'h3C, 1'b1,
      typed_map(8'h30, 1'b1, 8'h00, 8'h00, 1'b0, 8'h30, 8'h00, 1'b1, MIRR_VERT, 1'b1)));
    // empty window
    plan.push_back(reg_row(REG_WINDOW_LOW, 16'hC000));
    plan.push_back(reg_row(REG_WINDOW_HIGH, 16'h4000));
    plan.push_back(access_row(MODE_WRITE, 16'hC000, 8'hAA, 8'hFF, 1'b0, '0));
    plan.push_back(access_row(MODE_WRITE, 16'h4000, 8'h55, 8'hFF, 1'b0, '0));
    plan.push_back(reg_row(REG_WINDOW_LOW, 16'h0000));
    plan.push_back(reg_row(REG_WINDOW_HIGH, 16'h0000));
    plan.push_back(reg_row(REG_BUS_CONFL, 16'd0));
    plan.push_back(reg_row(REG_LATCH_INIT, 16'h00FF));
    plan.push_back(reg_row(REG_HDR_MIRR, 16'(MIRR_SCREEN_B)));
    plan.push_back(reg_row(REG_VARIANT, 16'(VAR_AXROM)));
    plan.push_back(access_row(MODE_WRITE, 16'h0000, 8'h1F, 8'h00, 1'b0, '0));
    plan.push_back(access_row(MODE_WRITE, 16'h0001, 8'h00, 8'h00, 1'b0, '0));
    plan.push_back(access_row(MODE_POWER, 16'h0000, 8'h00, 8'h00, 1'b0, '0));
    // spare variant code keeps mirroring
    plan.push_back(reg_row(REG_VARIANT, 16'(VAR_SPARE_LAST)));
    plan.push_back(reg_row(REG_WINDOW_HIGH, 16'hFFFF));
    plan.push_back(access_row(MODE_WRITE, 16'h1234, 8'hA5, 8'h00, 1'b1,
      typed_map(8'hA5, 1'b1, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0, MIRR_SCREEN_B, 1'b1)));
    plan.push_back(access_row(MODE_POWER, 16'hFFFF, 8'hFF, 8'hFF, 1'b1,
      typed_map(8'hFF, 1'b1, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0, MIRR_SCREEN_B, 1'b1)));
    plan.push_back(reg_row(REG_VARIANT, 16'(VAR_A65AS)));
    plan.push_back(access_row(MODE_WRITE, 16'h8000, 8'h5E, 8'h00, 1'b0, '0));
    plan.push_back(access_row(MODE_WRITE, 16'h8000, 8'hA5, 8'h00, 1'b0, '0));
    plan.push_back(reg_row(REG_VARIANT, 16'(VAR_B97)));
    plan.push_back(access_row(MODE_WRITE, 16'hA000, 8'h40, 8'h00, 1'b0, '0));
    plan.push_back(access_row(MODE_WRITE, 16'hA000, 8'h80, 8'h00, 1'b0, '0));
    plan.push_back(access_row(MODE_WRITE, 16'hA000, 8'hC0, 8'h00, 1'b0, '0));
    plan.push_back(reg_row(REG_VARIANT, 16'(VAR_B184)));
    plan.push_back(access_row(MODE_WRITE, 16'hFFFF, 8'hFF, 8'h00, 1'b1,
      typed_map(8'hFF, 1'b1, 8'h00, 8'h00, 1'b1, 8'hFF, 8'h0F, 1'b0, MIRR_VERT, 1'b1)));
    plan.push_back(access_row(MODE_WRITE, 16'hFFFF, 8'h5A, 8'hC3, 1'b0, '0));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[k]) begin
      if (plan[k].is_cfg) begin
        drain();
        write_reg(plan[k].idx, plan[k].wdata);
      end else begin
        send_access(plan[k].acc, plan[k].typed, plan[k].want);
      end
    end

    // random phases: new settings each time, variants walked in order first
    sent = 0;
    phase = 0;
    while (sent < ITEM_TARGET) begin
      drain();
      steady = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 7))
        0: begin
          lo = 0;
          hi = 'hFFFF;
        end
        1: begin
          lo = $urandom_range(1, 'hFFFF);
          hi = $urandom_range(0, lo - 1);
        end
        2: begin
          lo = $urandom_range(0, 'hFFFF);
          hi = lo;
        end
        3: begin
          lo = 32'(WINDOW_LOW_RST);
          hi = 32'(WINDOW_HIGH_RST);
        end
        default: begin
          lo = $urandom_range(0, 'hFFFF);
          hi = $urandom_range(lo, 'hFFFF);
        end
      endcase
      if (phase <= VAR_SPARE_LAST) write_reg(REG_VARIANT, 16'(phase));
      else if ($urandom_range(0, 7) == 0)
        write_reg(REG_VARIANT, 16'($urandom_range(VAR_SPARE_FIRST, VAR_SPARE_LAST)));
      else write_reg(REG_VARIANT, 16'($urandom_range(VAR_UNROM, VAR_M11160)));
      write_reg(REG_LATCH_INIT, 16'($urandom_range(0, 255)));
      write_reg(REG_WINDOW_LOW, 16'(lo));
      write_reg(REG_WINDOW_HIGH, 16'(hi));
      write_reg(REG_BUS_CONFL, 16'($urandom_range(0, 1)));
      write_reg(REG_LARGE_PRG, 16'($urandom_range(0, 1)));
      write_reg(REG_HDR_MIRR, 16'($urandom_range(0, 3)));
      n = $urandom_range(16, 48);
      repeat (n) begin
        acc.mode = ($urandom_range(0, 11) == 0) ? MODE_POWER : MODE_WRITE;
        if (lo <= hi && $urandom_range(0, 9) < 7) acc.address = 16'($urandom_range(lo, hi));
        else acc.address = 16'($urandom_range(0, 'hFFFF));
        acc.data = 8'($urandom_range(0, 255));
        acc.rom_byte = 8'($urandom_range(0, 255));
        send_access(acc, 1'b0, '0);
        sent++;
      end
      phase++;
    end

    drain();
    repeat (LATENCY + 2) @(posedge clk_i);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
